// ===== src/dbhl_pkg.sv =====
// Shared types and constants of the bilinear height lookup.
package dbhl_pkg;

  // Request field widths, fixed by the request format.
  localparam int IDX_W    = 21;
  localparam int HEIGHT_W = 16;
  localparam int OFF_W    = 16;

  // Register stages from the request port to the result register.
  localparam int NUM_STAGES = 16;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_t;

endpackage

// ===== src/dbhl_if.sv =====
// Valid/ready channel interfaces for requests and height results.
interface dbhl_req_if;
  logic                                  valid;
  logic                                  ready;
  dbhl_pkg::req_type_t                   req_type;
  logic        [dbhl_pkg::IDX_W-1:0]     sample_index;
  logic signed [dbhl_pkg::HEIGHT_W-1:0]  sample_height;
  logic        [dbhl_pkg::OFF_W-1:0]     lat_offset;
  logic        [dbhl_pkg::OFF_W-1:0]     lon_offset;

  modport source (
    output valid, req_type, sample_index, sample_height, lat_offset, lon_offset,
    input  ready
  );
  modport sink (
    input  valid, req_type, sample_index, sample_height, lat_offset, lon_offset,
    output ready
  );
endinterface

interface dbhl_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [dbhl_pkg::HEIGHT_W-1:0]  ground_height;

  modport source (
    output valid, ground_height,
    input  ready
  );
  modport sink (
    input  valid, ground_height,
    output ready
  );
endinterface

// ===== src/dbhl_bank.sv =====
// Single-port RAM bank with a registered read port.
module dbhl_bank #(
  parameter int DEPTH = 361201,
  parameter int AW    = 19,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== src/dem_bilinear_height_lookup.sv =====
// Top level of the bilinear height lookup over one elevation tile.
//
// The block stores one square tile of POINTS_PER_ROW x POINTS_PER_ROW signed
// 16-bit heights, loaded one sample per load transfer in file order, and
// answers height queries with the bilinear interpolation of the four corners
// of the grid cell that holds the position, truncated toward zero. Loads and
// queries share one 16-stage pipeline and both may be sent in every cycle:
// the sustained rate is one request per clock while the result channel does
// not stall. The tile sits in four single-port banks split by row and column
// parity, so the four corners of any cell are read in the same cycle, one per
// bank; a load writes one bank at the same pipeline point, so a query always
// sees every load sent before it. Load indexes past the tile are dropped. A
// sample must be loaded before a query uses it: the banks are not cleared
// after reset, and there is no clearing pass.
module dem_bilinear_height_lookup #(
  parameter int POINTS_PER_ROW   = 1201,
  parameter int SECONDS_PER_CELL = 3,
  parameter int SUBSECOND_BITS   = 4
) (
  input logic         clk,
  input logic         rst,
  dbhl_req_if.sink    req,
  dbhl_rsp_if.source  rsp
);

  localparam int IW = dbhl_pkg::IDX_W;
  localparam int HW = dbhl_pkg::HEIGHT_W;
  localparam int OW = dbhl_pkg::OFF_W;
  localparam int NS = dbhl_pkg::NUM_STAGES;

  localparam int P          = POINTS_PER_ROW;
  localparam int TILE_DEPTH = P * P;
  localparam int C          = SECONDS_PER_CELL << SUBSECOND_BITS;
  localparam int D          = SECONDS_PER_CELL * SECONDS_PER_CELL;
  localparam int RC_W       = $clog2(P);
  localparam int FR_W       = $clog2(C + 1);
  localparam int HALF       = (P + 1) / 2;
  localparam int BANK_DEPTH = HALF * HALF;
  localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int W_W        = 2 * FR_W;
  localparam int P_W        = HW + W_W + 1;
  localparam int SUM_W      = P_W + 2;
  localparam int MAG_W      = SUM_W - 2 * SUBSECOND_BITS;
  localparam int QW         = HW + 1;

  localparam longint OFF_MAX = longint'(P - 1) * longint'(C);
  localparam longint MR      = (longint'(1) << IW) / longint'(P);
  localparam longint MC      = (longint'(1) << OW) / longint'(C);
  localparam longint MD      = (longint'(1) << MAG_W) / longint'(D);

  localparam logic [31:0]     OFF_MAX_C = 32'(OFF_MAX);
  localparam logic [31:0]     DEPTH_C   = 32'(TILE_DEPTH);
  localparam logic [IW-1:0]   MR_C      = IW'(MR);
  localparam logic [OW:0]     MC_C      = (OW + 1)'(MC);
  localparam logic [MAG_W:0]  MD_C      = (MAG_W + 1)'(MD);
  localparam logic [IW-1:0]   P_IDX     = IW'(P);
  localparam logic [OW-1:0]   C_OFF     = OW'(C);
  localparam logic [OW-1:0]   PM1_OFF   = OW'(P - 1);
  localparam logic [FR_W-1:0] C_FR      = FR_W'(C);
  localparam logic [RC_W-1:0] PM1_RC    = RC_W'(P - 1);
  localparam logic [RC_W-1:0] PM2_RC    = RC_W'(P - 2);
  localparam logic [BA_W-1:0] HALF_BA   = BA_W'(HALF);
  localparam logic [MAG_W-1:0] D_MAG    = MAG_W'(D);
  localparam logic [QW-1:0]   HMAX_Q    = QW'((1 << (HW - 1)) - 1);

  // Pipeline control: a stage loads when it is empty or its successor loads.
  logic [NS:1]   v;
  logic [NS:1]   vin;
  logic [NS+1:1] rdy;

  assign rdy[NS+1] = rsp.ready;
  for (genvar k = 1; k <= NS; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end

  // Loads leave the pipeline once they have written their bank.
  logic s6_q;
  always_comb begin
    vin[1] = req.valid;
    for (int k = 2; k <= NS; k++) begin
      vin[k] = v[k-1];
    end
    vin[7] = v[6] && s6_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (rdy[k]) begin
          v[k] <= vin[k];
        end
      end
    end
  end

  assign req.ready = rdy[1];

  // Stage 1: capture, range check and edge saturation.
  logic              s1_q, s1_inr;
  logic [IW-1:0]     s1_idx;
  logic signed [HW-1:0] s1_hgt;
  logic [OW-1:0]     s1_lat, s1_lon;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_q   <= (req.req_type == dbhl_pkg::REQ_QUERY);
      s1_idx <= req.sample_index;
      s1_hgt <= req.sample_height;
      s1_inr <= (32'(req.sample_index) < DEPTH_C);
      s1_lat <= (32'(req.lat_offset) > OFF_MAX_C) ? OFF_MAX_C[OW-1:0] : req.lat_offset;
      s1_lon <= (32'(req.lon_offset) > OFF_MAX_C) ? OFF_MAX_C[OW-1:0] : req.lon_offset;
    end
  end

  // Stage 2: reciprocal products estimate row and cell indexes.
  logic [2*IW-1:0] idx_prod;
  logic [2*OW:0]   lat_prod, lon_prod;
  assign idx_prod = (2 * IW)'(s1_idx) * (2 * IW)'(MR_C);
  assign lat_prod = (2 * OW + 1)'(s1_lat) * (2 * OW + 1)'(MC_C);
  assign lon_prod = (2 * OW + 1)'(s1_lon) * (2 * OW + 1)'(MC_C);

  logic              s2_q, s2_inr;
  logic [IW-1:0]     s2_idx, s2_row;
  logic signed [HW-1:0] s2_hgt;
  logic [OW-1:0]     s2_lat, s2_lon, s2_cy, s2_cx;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_q   <= s1_q;
      s2_inr <= s1_inr;
      s2_idx <= s1_idx;
      s2_hgt <= s1_hgt;
      s2_lat <= s1_lat;
      s2_lon <= s1_lon;
      s2_row <= idx_prod[2*IW-1:IW];
      s2_cy  <= lat_prod[2*OW-1:OW];
      s2_cx  <= lon_prod[2*OW-1:OW];
    end
  end

  // Stage 3: multiply the estimates back.
  logic              s3_q, s3_inr;
  logic [IW-1:0]     s3_idx, s3_row, s3_rowp;
  logic signed [HW-1:0] s3_hgt;
  logic [OW-1:0]     s3_lat, s3_lon, s3_cy, s3_cx, s3_laty, s3_lonx;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_q    <= s2_q;
      s3_inr  <= s2_inr;
      s3_idx  <= s2_idx;
      s3_hgt  <= s2_hgt;
      s3_lat  <= s2_lat;
      s3_lon  <= s2_lon;
      s3_row  <= s2_row;
      s3_cy   <= s2_cy;
      s3_cx   <= s2_cx;
      s3_rowp <= IW'((2 * IW)'(s2_row) * (2 * IW)'(P));
      s3_laty <= OW'((2 * OW)'(s2_cy) * (2 * OW)'(C));
      s3_lonx <= OW'((2 * OW)'(s2_cx) * (2 * OW)'(C));
    end
  end

  // Stage 4: the estimates are low by at most one; correct them.
  logic [IW-1:0] idx_rem;
  logic [OW-1:0] lat_rem, lon_rem;
  assign idx_rem = s3_idx - s3_rowp;
  assign lat_rem = s3_lat - s3_laty;
  assign lon_rem = s3_lon - s3_lonx;

  logic              s4_q, s4_inr;
  logic signed [HW-1:0] s4_hgt;
  logic [RC_W-1:0]   s4_row, s4_col;
  logic [OW-1:0]     s4_y, s4_x;
  logic [FR_W-1:0]   s4_fy, s4_fx;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_q   <= s3_q;
      s4_inr <= s3_inr;
      s4_hgt <= s3_hgt;
      if (idx_rem >= P_IDX) begin
        s4_row <= RC_W'(s3_row + 1'b1);
        s4_col <= RC_W'(idx_rem - P_IDX);
      end else begin
        s4_row <= RC_W'(s3_row);
        s4_col <= RC_W'(idx_rem);
      end
      if (lat_rem >= C_OFF) begin
        s4_y  <= s3_cy + 1'b1;
        s4_fy <= FR_W'(lat_rem - C_OFF);
      end else begin
        s4_y  <= s3_cy;
        s4_fy <= FR_W'(lat_rem);
      end
      if (lon_rem >= C_OFF) begin
        s4_x  <= s3_cx + 1'b1;
        s4_fx <= FR_W'(lon_rem - C_OFF);
      end else begin
        s4_x  <= s3_cx;
        s4_fx <= FR_W'(lon_rem);
      end
    end
  end

  // Stage 5: a position on the far edge uses the last cell with a full
  // fraction. Rows are turned into rows from the north.
  logic            y_edge, x_edge;
  logic [RC_W-1:0] yc, xc;
  logic [FR_W-1:0] fyc, fxc;
  assign y_edge = (s4_y == PM1_OFF);
  assign x_edge = (s4_x == PM1_OFF);
  assign yc     = y_edge ? PM2_RC : RC_W'(s4_y);
  assign xc     = x_edge ? PM2_RC : RC_W'(s4_x);
  assign fyc    = y_edge ? C_FR : s4_fy;
  assign fxc    = x_edge ? C_FR : s4_fx;

  logic              s5_q, s5_inr;
  logic signed [HW-1:0] s5_hgt;
  logic [RC_W-1:0]   s5_rn0, s5_rn1, s5_c0, s5_c1;
  logic [FR_W-1:0]   s5_wx0, s5_wx1, s5_wy0, s5_wy1;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_q   <= s4_q;
      s5_inr <= s4_inr;
      s5_hgt <= s4_hgt;
      if (s4_q) begin
        s5_rn0 <= PM2_RC - yc;
        s5_rn1 <= PM1_RC - yc;
        s5_c0  <= xc;
        s5_c1  <= xc + 1'b1;
      end else begin
        s5_rn0 <= s4_row;
        s5_rn1 <= s4_row;
        s5_c0  <= s4_col;
        s5_c1  <= s4_col;
      end
      s5_wx0 <= C_FR - fxc;
      s5_wx1 <= fxc;
      s5_wy0 <= C_FR - fyc;
      s5_wy1 <= fyc;
    end
  end

  // Stage 6: bank addresses. Bank bit 1 is the row parity, bit 0 the
  // column parity; a load targets one bank, a query touches all four.
  logic [RC_W-1:0] row_sel [4];
  logic [RC_W-1:0] col_sel [4];
  logic [3:0]      bank_hit;

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      row_sel[g]  = (s5_rn0[0] == 1'(g >> 1)) ? s5_rn0 : s5_rn1;
      col_sel[g]  = (s5_c0[0] == 1'(g)) ? s5_c0 : s5_c1;
      bank_hit[g] = (s5_rn0[0] == 1'(g >> 1)) && (s5_c0[0] == 1'(g));
    end
  end

  logic              s6_ps, s6_pw;
  logic signed [HW-1:0] s6_hgt;
  logic [BA_W-1:0]   s6_addr [4];
  logic [3:0]        s6_we;
  logic [FR_W-1:0]   s6_wx0, s6_wx1, s6_wy0, s6_wy1;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_q   <= s5_q;
      s6_hgt <= s5_hgt;
      s6_ps  <= s5_rn1[0];
      s6_pw  <= s5_c0[0];
      s6_wx0 <= s5_wx0;
      s6_wx1 <= s5_wx1;
      s6_wy0 <= s5_wy0;
      s6_wy1 <= s5_wy1;
      for (int g = 0; g < 4; g++) begin
        s6_addr[g] <= BA_W'(row_sel[g] >> 1) * HALF_BA + BA_W'(col_sel[g] >> 1);
        s6_we[g]   <= !s5_q && s5_inr && bank_hit[g];
      end
    end
  end

  // Stage 7: bank access. The access happens only as the item moves on, so
  // a stalled load writes once and a stalled query keeps its read data.
  logic          bank_en;
  logic [HW-1:0] bank_q [4];
  assign bank_en = rdy[7] && v[6];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    dbhl_bank #(
      .DEPTH (BANK_DEPTH),
      .AW    (BA_W),
      .DW    (HW)
    ) u_bank (
      .clk   (clk),
      .en    (bank_en),
      .we    (s6_we[b]),
      .addr  (s6_addr[b]),
      .wdata (s6_hgt),
      .rdata (bank_q[b])
    );
  end

  logic            s7_ps, s7_pw;
  logic [FR_W-1:0] s7_wx0, s7_wx1, s7_wy0, s7_wy1;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_ps  <= s6_ps;
      s7_pw  <= s6_pw;
      s7_wx0 <= s6_wx0;
      s7_wx1 <= s6_wx1;
      s7_wy0 <= s6_wy0;
      s7_wy1 <= s6_wy1;
    end
  end

  // Stage 8: banks to corners (south-west, south-east, north-west,
  // north-east) and the corner weights.
  logic [HW-1:0] h00, h10, h01, h11;
  always_comb begin
    unique case ({s7_ps, s7_pw})
      2'b00: begin
        h00 = bank_q[0]; h10 = bank_q[1]; h01 = bank_q[2]; h11 = bank_q[3];
      end
      2'b01: begin
        h00 = bank_q[1]; h10 = bank_q[0]; h01 = bank_q[3]; h11 = bank_q[2];
      end
      2'b10: begin
        h00 = bank_q[2]; h10 = bank_q[3]; h01 = bank_q[0]; h11 = bank_q[1];
      end
      default: begin
        h00 = bank_q[3]; h10 = bank_q[2]; h01 = bank_q[1]; h11 = bank_q[0];
      end
    endcase
  end

  logic signed [HW-1:0] s8_h [4];
  logic [W_W-1:0]       s8_w [4];

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      s8_h[0] <= h00;
      s8_h[1] <= h10;
      s8_h[2] <= h01;
      s8_h[3] <= h11;
      s8_w[0] <= W_W'(s7_wx0) * W_W'(s7_wy0);
      s8_w[1] <= W_W'(s7_wx1) * W_W'(s7_wy0);
      s8_w[2] <= W_W'(s7_wx0) * W_W'(s7_wy1);
      s8_w[3] <= W_W'(s7_wx1) * W_W'(s7_wy1);
    end
  end

  // Stage 9: weighted corner heights.
  logic signed [P_W-1:0] s9_p [4];

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      for (int i = 0; i < 4; i++) begin
        s9_p[i] <= P_W'(s8_h[i]) * P_W'($signed({1'b0, s8_w[i]}));
      end
    end
  end

  // Stages 10 and 11: sum tree.
  logic signed [P_W:0]     s10_a, s10_b;
  logic signed [SUM_W-1:0] s11_sum;

  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      s10_a <= (P_W + 1)'(s9_p[0]) + (P_W + 1)'(s9_p[1]);
      s10_b <= (P_W + 1)'(s9_p[2]) + (P_W + 1)'(s9_p[3]);
    end
    if (rdy[11]) begin
      s11_sum <= SUM_W'(s10_a) + SUM_W'(s10_b);
    end
  end

  // Stage 12: magnitude; the power-of-two part of the cell area is a shift.
  logic [SUM_W-1:0] abs_sum;
  assign abs_sum = s11_sum[SUM_W-1] ? $unsigned(-s11_sum) : $unsigned(s11_sum);

  logic             s12_neg;
  logic [MAG_W-1:0] s12_mag;

  always_ff @(posedge clk) begin
    if (rdy[12]) begin
      s12_neg <= s11_sum[SUM_W-1];
      s12_mag <= MAG_W'(abs_sum >> (2 * SUBSECOND_BITS));
    end
  end

  // Stages 13 to 15: divide by the squared cell size in seconds through a
  // reciprocal estimate and one correction step.
  logic [2*MAG_W:0] mag_prod;
  assign mag_prod = (2 * MAG_W + 1)'(s12_mag) * (2 * MAG_W + 1)'(MD_C);

  logic             s13_neg, s14_neg, s15_neg;
  logic [MAG_W-1:0] s13_mag, s14_mag, s14_qd;
  logic [QW-1:0]    s13_qe, s14_qe, s15_q;
  logic [MAG_W-1:0] mag_rem;
  assign mag_rem = s14_mag - s14_qd;

  always_ff @(posedge clk) begin
    if (rdy[13]) begin
      s13_neg <= s12_neg;
      s13_mag <= s12_mag;
      s13_qe  <= mag_prod[MAG_W+QW-1:MAG_W];
    end
    if (rdy[14]) begin
      s14_neg <= s13_neg;
      s14_mag <= s13_mag;
      s14_qe  <= s13_qe;
      s14_qd  <= MAG_W'((MAG_W + QW)'(s13_qe) * (MAG_W + QW)'(D));
    end
    if (rdy[15]) begin
      s15_neg <= s14_neg;
      s15_q   <= (mag_rem >= D_MAG) ? s14_qe + 1'b1 : s14_qe;
    end
  end

  // Stage 16: sign and clamp into the result register.
  logic signed [HW-1:0] s16_gh;

  always_ff @(posedge clk) begin
    if (rdy[16]) begin
      if (s15_neg) begin
        s16_gh <= HW'(-s15_q);
      end else if (s15_q > HMAX_Q) begin
        s16_gh <= HW'(HMAX_Q);
      end else begin
        s16_gh <= HW'(s15_q);
      end
    end
  end

  assign rsp.valid         = v[NS];
  assign rsp.ground_height = s16_gh;

endmodule

// ===== src/dbhl_checker.sv =====
// Port-level checks of the bilinear height lookup and their binding.
module dbhl_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 req_valid,
  input logic                                 req_ready,
  input dbhl_pkg::req_type_t                  req_type,
  input logic                                 rsp_valid,
  input logic                                 rsp_ready,
  input logic signed [dbhl_pkg::HEIGHT_W-1:0] ground_height
);

  localparam int CNT_W = $clog2(dbhl_pkg::NUM_STAGES + 1) + 1;

  // Queries taken in whose result has not yet been transferred.
  logic [CNT_W-1:0] pending;
  logic             q_in, r_out;

  assign q_in  = req_valid && req_ready && (req_type == dbhl_pkg::REQ_QUERY);
  assign r_out = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + CNT_W'(q_in) - CNT_W'(r_out);
    end
  end

  a_rsp_hold : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result withdrawn before transfer");

  a_rsp_stable : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(ground_height))
    else $error("stalled result changed");

  a_no_orphan : assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != '0)
    else $error("result offered with no query outstanding");

  a_bounded : assert property (@(posedge clk) disable iff (rst)
    pending <= CNT_W'(dbhl_pkg::NUM_STAGES))
    else $error("more queries in flight than pipeline stages");

endmodule

bind dem_bilinear_height_lookup dbhl_checker u_dbhl_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_type      (req.req_type),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .ground_height (rsp.ground_height)
);

// ===== tb/sv/tb_dem_bilinear_height_lookup.sv =====
// Testbench for the bilinear height lookup: loads tile samples, queries heights, checks results.
`timescale 1ns / 100ps

module tb_dem_bilinear_height_lookup;

  localparam int POINTS           = 1201;
  localparam int SECONDS_PER_CELL = 3;
  localparam int SUBSECOND_BITS   = 4;
  localparam int CELL_UNITS       = SECONDS_PER_CELL * (1 << SUBSECOND_BITS);
  localparam int TILE_DEPTH       = POINTS * POINTS;
  localparam int MAX_OFFSET       = (POINTS - 1) * CELL_UNITS;
  localparam int LAST_CELL        = POINTS - 2;
  localparam int ITEM_TARGET      = 1300;
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int CYCLE_LIMIT      = 400000;

  typedef struct {
    dbhl_pkg::req_type_t              kind;
    logic [dbhl_pkg::IDX_W-1:0]       idx;
    logic signed [15:0]               height;
    logic [dbhl_pkg::OFF_W-1:0]       lat;
    logic [dbhl_pkg::OFF_W-1:0]       lon;
  } lookup_req_t;

  logic clk;
  logic rst;

  dbhl_req_if req_ch ();
  dbhl_rsp_if rsp_ch ();

  dem_bilinear_height_lookup #(
    .POINTS_PER_ROW  (POINTS),
    .SECONDS_PER_CELL(SECONDS_PER_CELL),
    .SUBSECOND_BITS  (SUBSECOND_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  lookup_req_t        pending_q[$];
  logic signed [15:0] expected_heights[$];
  logic signed [15:0] tile_model[int unsigned];
  int                 loaded_cells[$];

  int offered_count   = 0;
  int accepted_count  = 0;
  int load_count      = 0;
  int dropped_loads   = 0;
  int query_count     = 0;
  int heights_checked = 0;
  int error_count     = 0;
  int cycle_count     = 0;
  bit pressure_done   = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- prediction

  function automatic void split_offset(input int unsigned off, output int unsigned cell_idx,
                                       output int unsigned frac);
    int unsigned c;
    if (off > MAX_OFFSET) off = MAX_OFFSET;
    c = off / CELL_UNITS;
    if (c > LAST_CELL) c = LAST_CELL;
    cell_idx = c;
    frac = off - c * CELL_UNITS;
  endfunction

  function automatic longint stored_height(input int unsigned col, input int unsigned row_s);
    int unsigned a;
    a = col + (POINTS - 1 - row_s) * POINTS;
    if (tile_model.exists(a)) return longint'(tile_model[a]);
    return 0;
  endfunction

  function automatic logic signed [15:0] interpolate_height(input logic [15:0] lat,
                                                            input logic [15:0] lon);
    int unsigned row_s, frac_y, col_w, frac_x;
    longint h00, h10, h01, h11, wx, wy, cu, acc, q;
    split_offset(32'(lat), row_s, frac_y);
    split_offset(32'(lon), col_w, frac_x);
    h00 = stored_height(col_w, row_s);
    h01 = stored_height(col_w, row_s + 1);
    h10 = stored_height(col_w + 1, row_s);
    h11 = stored_height(col_w + 1, row_s + 1);
    cu = CELL_UNITS;
    wx = frac_x;
    wy = frac_y;
    acc = h00 * (cu - wx) * (cu - wy) + h10 * wx * (cu - wy)
        + h01 * (cu - wx) * wy + h11 * wx * wy;
    // SystemVerilog division of signed operands truncates toward zero.
    q = acc / (cu * cu);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic int unsigned grid_index(input int col, input int row_s);
    return col + (POINTS - 1 - row_s) * POINTS;
  endfunction

  function automatic void add_load(input int unsigned idx, input logic signed [15:0] h);
    lookup_req_t it;
    it.kind   = dbhl_pkg::REQ_LOAD;
    it.idx    = idx[dbhl_pkg::IDX_W-1:0];
    it.height = h;
    it.lat    = 16'($urandom_range(0, 65535));
    it.lon    = 16'($urandom_range(0, 65535));
    pending_q.push_back(it);
  endfunction

  function automatic void add_query(input int unsigned lat, input int unsigned lon);
    lookup_req_t it;
    int unsigned junk_idx;
    junk_idx  = $urandom_range(0, (1 << dbhl_pkg::IDX_W) - 1);
    it.kind   = dbhl_pkg::REQ_QUERY;
    it.idx    = junk_idx[dbhl_pkg::IDX_W-1:0];
    it.height = 16'($urandom);
    it.lat    = lat[15:0];
    it.lon    = lon[15:0];
    pending_q.push_back(it);
  endfunction

  function automatic void load_corners(input int x, input int y, input logic signed [15:0] h00,
                                       input logic signed [15:0] h10,
                                       input logic signed [15:0] h01,
                                       input logic signed [15:0] h11);
    add_load(grid_index(x, y), h00);
    add_load(grid_index(x + 1, y), h10);
    add_load(grid_index(x, y + 1), h01);
    add_load(grid_index(x + 1, y + 1), h11);
    loaded_cells.push_back(x * 2048 + y);
  endfunction

  function automatic logic signed [15:0] random_height();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'sh7fff;
    if (r < 10) return -16'sd32768;
    // Small values make the truncation toward zero visible.
    if (r < 35) return 16'(int'($urandom_range(0, 6)) - 3);
    return 16'($urandom);
  endfunction

  function automatic int pick_grid_cell();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 20) return LAST_CELL;
    return $urandom_range(0, LAST_CELL);
  endfunction

  function automatic int unsigned pick_offset(input int cell_idx);
    int r;
    r = $urandom_range(0, 99);
    // On the last cell, offsets at or past the far edge saturate to the edge.
    if (cell_idx == LAST_CELL && r < 25) return $urandom_range(MAX_OFFSET, 65535);
    if (r < 35) return cell_idx * CELL_UNITS;
    if (r < 45) return cell_idx * CELL_UNITS + CELL_UNITS - 1;
    return cell_idx * CELL_UNITS + $urandom_range(0, CELL_UNITS - 1);
  endfunction

  function automatic void query_in_cell(input int x, input int y);
    add_query(pick_offset(y), pick_offset(x));
  endfunction

  // Idle length after a transfer: mostly none or short, now and then long,
  // with occasional runs that have no idling at all.
  function automatic int pick_idle(inout int run_left);
    int r;
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      run_left = $urandom_range(30, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------- driver

  int          req_gap_left = 0;
  int          req_run_left = 0;
  lookup_req_t req_next;

  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid         <= 1'b0;
      req_ch.req_type      <= dbhl_pkg::REQ_LOAD;
      req_ch.sample_index  <= '0;
      req_ch.sample_height <= '0;
      req_ch.lat_offset    <= '0;
      req_ch.lon_offset    <= '0;
    end else if (offered_count != accepted_count) begin
      // The offered transfer has not been taken yet; hold it.
    end else if (req_gap_left > 0) begin
      req_ch.valid <= 1'b0;
      req_gap_left--;
    end else if (pending_q.size() > 0) begin
      req_next = pending_q.pop_front();
      req_ch.valid         <= 1'b1;
      req_ch.req_type      <= req_next.kind;
      req_ch.sample_index  <= req_next.idx;
      req_ch.sample_height <= req_next.height;
      req_ch.lat_offset    <= req_next.lat;
      req_ch.lon_offset    <= req_next.lon;
      offered_count++;
      req_gap_left = pick_idle(req_run_left);
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- receiver

  int rsp_stall_left = 0;
  int rsp_run_left   = 0;
  int hold_left      = 0;

  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left--;
    end else if (!pressure_done && heights_checked >= 300) begin
      // Long hold-off so the pipeline fills and the request side stalls.
      pressure_done = 1;
      hold_left = HOLD_OFF_CYCLES - 1;
      rsp_ch.ready <= 1'b0;
    end else if (rsp_stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall_left--;
    end else begin
      rsp_ch.ready <= 1'b1;
      rsp_stall_left = pick_idle(rsp_run_left);
    end
  end

  // ---------------------------------------------------------------- monitor

  logic signed [15:0] height_exp;

  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        accepted_count++;
        if (req_ch.req_type == dbhl_pkg::REQ_LOAD) begin
          if (req_ch.sample_index < TILE_DEPTH) begin
            tile_model[req_ch.sample_index] = req_ch.sample_height;
            load_count++;
          end else begin
            dropped_loads++;
          end
        end else begin
          expected_heights.push_back(interpolate_height(req_ch.lat_offset, req_ch.lon_offset));
          query_count++;
        end
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_heights.size() == 0) begin
          $display("%0t: unexpected height transfer: expected none, actual %0d",
                   $time, rsp_ch.ground_height);
          error_count++;
        end else begin
          height_exp = expected_heights.pop_front();
          if (rsp_ch.ground_height !== height_exp) begin
            $display("%0t: ground_height mismatch: expected %0d, actual %0d",
                     $time, height_exp, rsp_ch.ground_height);
            error_count++;
          end
          heights_checked++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- timeout

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d heights outstanding",
             $time, cycle_count, expected_heights.size());
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- main

  initial begin
    int item_total;
    int seq_kind;
    int x;
    int y;
    int pick;
    int n_queries;

    rst = 1'b1;

    // Directed: full-scale corners in the south-west cell.
    load_corners(0, 0, -16'sd32768, 16'sh7fff, 16'sh7fff, -16'sd32768);
    add_query(0, 0);
    add_query(CELL_UNITS - 1, CELL_UNITS - 1);
    add_query(CELL_UNITS / 2, CELL_UNITS / 2);
    // A small negative sum that must truncate toward zero.
    load_corners(5, 5, -16'sd1, 16'sd0, 16'sd0, 16'sd0);
    add_query(5 * CELL_UNITS + CELL_UNITS / 2, 5 * CELL_UNITS + CELL_UNITS / 2);
    // North-east cell: saturated offsets and the exact far edge.
    load_corners(LAST_CELL, LAST_CELL, 16'sd100, -16'sd200, 16'sd300, -16'sd400);
    add_query(65535, 65535);
    add_query(MAX_OFFSET, MAX_OFFSET);
    // South-east cell holds the last index of the tile.
    load_corners(LAST_CELL, 0, 16'sd7, 16'sh7fff, -16'sd5, 16'sd9);
    add_query(0, 65535);
    // Loads past the tile are dropped; the first cell must be unchanged.
    add_load(TILE_DEPTH, 16'sh1234);
    add_load((1 << dbhl_pkg::IDX_W) - 1, -16'sd1);
    add_query(0, 0);
    item_total = pending_q.size() - 2;

    // Random: mostly complete cell loads followed by queries inside the cell.
    while (item_total < ITEM_TARGET) begin
      seq_kind = $urandom_range(0, 99);
      if (seq_kind < 60 || loaded_cells.size() == 0) begin
        x = pick_grid_cell();
        y = pick_grid_cell();
        load_corners(x, y, random_height(), random_height(), random_height(), random_height());
        n_queries = $urandom_range(1, 4);
        repeat (n_queries) query_in_cell(x, y);
        item_total += 4 + n_queries;
      end else if (seq_kind < 80) begin
        pick = loaded_cells[$urandom_range(0, loaded_cells.size() - 1)];
        x = pick / 2048;
        y = pick % 2048;
        if ($urandom_range(0, 1)) begin
          add_load(grid_index(x + $urandom_range(0, 1), y + $urandom_range(0, 1)),
                   random_height());
          item_total++;
        end
        n_queries = $urandom_range(1, 3);
        repeat (n_queries) query_in_cell(x, y);
        item_total += n_queries;
      end else if (seq_kind < 90) begin
        add_load($urandom_range(0, TILE_DEPTH - 1), random_height());
        item_total++;
      end else begin
        add_load($urandom_range(TILE_DEPTH, (1 << dbhl_pkg::IDX_W) - 1), random_height());
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || offered_count != accepted_count) @(posedge clk);
    while (expected_heights.size() != 0) @(posedge clk);
    // Let any stray result surface after the last expected one.
    repeat (dbhl_pkg::NUM_STAGES * 4) @(posedge clk);

    $display("Covered %0d loads into the tile, %0d dropped out-of-tile loads, %0d queries.",
             load_count, dropped_loads, query_count);
    $display("Checked %0d interpolated heights in %0d cycles, %0d mismatches.",
             heights_checked, cycle_count, error_count);
    if (error_count == 0 && expected_heights.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
